@@ rtl/core/cbdp_pkg.sv @@
// Package for the codebook int8 dot product block.
// Holds shared widths, lane limits and register index codes; no dependencies.
`timescale 1ns / 1ps

package cbdp_pkg;

   // lane count limits and defaults
   localparam int MAX_LANES     = 16;
   localparam int LANES_DEFAULT = 16;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 64;
   localparam int PAIR_W  = 2 * WORD_W;
   localparam int PROD_W  = 2 * BYTE_W;
   localparam int TREE_W  = PROD_W + $clog2(MAX_LANES);
   localparam int ACC_W   = 32;

   // codebook geometry: index bytes at or above this give a zero weight
   localparam int CODEBOOK_SIZE = 16;
   localparam int CB_SEL_W      = $clog2(CODEBOOK_SIZE);

   // adder tree in heap layout: root at 0, leaves from MAX_LANES-1 upwards
   localparam int TREE_NODES    = 2 * MAX_LANES - 1;
   localparam int TREE_INNER    = MAX_LANES - 1;

   // control and status register indexes
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODEBOOK_LOW  = 2'd0,
      CSR_CODEBOOK_HIGH = 2'd1
   } csr_index_type;

   typedef logic signed [PROD_W-1:0] prod_type;

endpackage

@@ rtl/core/cbdp_lane.sv @@
// One lane of the dot product: codebook lookup and signed 8x8 multiply.
// Depends on cbdp_pkg.
`timescale 1ns / 1ps

module cbdp_lane
   import cbdp_pkg::*;
(
   input  logic [PAIR_W-1:0] codebook,
   input  logic [BYTE_W-1:0] index_byte,
   input  logic [BYTE_W-1:0] act_byte,
   output prod_type          product
);

   logic signed [BYTE_W-1:0] weight;
   logic signed [BYTE_W-1:0] act;
   logic                     out_of_table;

   // indexes beyond the codebook select a zero weight
   assign out_of_table = (index_byte[BYTE_W-1:CB_SEL_W] != '0);

   always_comb begin
      if (out_of_table) begin
         weight = '0;
      end else begin
         weight = codebook[BYTE_W*index_byte[CB_SEL_W-1:0] +: BYTE_W];
      end
   end

   assign act     = act_byte;
   assign product = weight * act;

endmodule

@@ rtl/core/cbdp_reduce.sv @@
// Adder tree that sums the lane products of one request.
// Depends on cbdp_pkg; unused lanes enter the tree as zero.
`timescale 1ns / 1ps

module cbdp_reduce
   import cbdp_pkg::*;
#(
   parameter int LANES = LANES_DEFAULT
) (
   input  prod_type                 products [0:LANES-1],
   output logic signed [TREE_W-1:0] chunk_sum
);

   logic signed [TREE_W-1:0] node [0:TREE_NODES-1];

   // leaves: sign extended products, zero above the lane count
   for (genvar i = 0; i < MAX_LANES; i++) begin : g_leaf
      if (i < LANES) begin : g_used
         assign node[TREE_INNER+i] =
            {{(TREE_W-PROD_W){products[i][PROD_W-1]}}, products[i]};
      end else begin : g_unused
         assign node[TREE_INNER+i] = '0;
      end
   end

   // inner nodes: each the sum of its two children
   for (genvar k = 0; k < TREE_INNER; k++) begin : g_node
      assign node[k] = node[2*k+1] + node[2*k+2];
   end

   assign chunk_sum = node[0];

endmodule

@@ rtl/core/codebook_int8_dot_product.sv @@
// Top level of the codebook int8 dot product block.
// Depends on cbdp_pkg, cbdp_lane and cbdp_reduce.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   req     | in        | req_valid / req_ready  | index_low/high, act_low/high, last
//   rsp     | out       | rsp_valid / rsp_ready  | dot_sum (signed 32 bit)
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata (64 bit)
//
// One request is taken every cycle while req_ready is high; a result for a request marked
// last shows on rsp_valid after it passes the input register, the product register
// (lookup and multiply), then adder tree and accumulator into the result register.
// Reset clears the pipeline, the accumulator and both codebook registers.
// A stalled result holds only the stages that must wait for it; requests not
// marked last keep flowing into the accumulator. csr_ready is always high.
`timescale 1ns / 1ps

module codebook_int8_dot_product
   import cbdp_pkg::*;
#(
   parameter int LANES = LANES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [WORD_W-1:0]       req_index_low,
   input  logic [WORD_W-1:0]       req_index_high,
   input  logic [WORD_W-1:0]       req_act_low,
   input  logic [WORD_W-1:0]       req_act_high,
   input  logic                    req_last,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ACC_W-1:0] rsp_dot_sum,
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]       csr_wdata
);

   // codebook registers
   logic [WORD_W-1:0] cb_low_ff,  cb_low_in;
   logic [WORD_W-1:0] cb_high_ff, cb_high_in;

   // stage 1: input register
   logic              s1_valid_ff, s1_valid_in;
   logic [PAIR_W-1:0] s1_index_ff;
   logic [PAIR_W-1:0] s1_act_ff;
   logic              s1_last_ff;

   // stage 2: product register
   logic              s2_valid_ff, s2_valid_in;
   prod_type          s2_prod_ff [0:LANES-1];
   prod_type          lane_prod  [0:LANES-1];
   logic              s2_last_ff;

   // accumulator and result register
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]  rsp_dot_sum_ff;
   logic signed [TREE_W-1:0] chunk_sum;
   logic [ACC_W-1:0]         row_sum;

   logic out_free, s2_move, s2_free, s1_move, s1_free, req_take;

   // flow control from the result end backwards
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_free   = !s2_valid_ff || s2_move;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_ready = s1_free;
   assign req_take  = req_valid && s1_free;

   // register writes; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cb_low_in  = cb_low_ff;
      cb_high_in = cb_high_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CODEBOOK_LOW: begin
               cb_low_in = csr_wdata;
            end
            CSR_CODEBOOK_HIGH: begin
               cb_high_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // lane lookup and multiply
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      cbdp_lane u_lane (
         .codebook   ({cb_high_ff, cb_low_ff}),
         .index_byte (s1_index_ff[BYTE_W*i +: BYTE_W]),
         .act_byte   (s1_act_ff[BYTE_W*i +: BYTE_W]),
         .product    (lane_prod[i])
      );
   end

   // sum of the lane products
   cbdp_reduce #(
      .LANES (LANES)
   ) u_reduce (
      .products  (s2_prod_ff),
      .chunk_sum (chunk_sum)
   );

   assign row_sum = acc_ff + {{(ACC_W-TREE_W){chunk_sum[TREE_W-1]}}, chunk_sum};

   // valid bits and accumulator
   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
      s2_valid_in  = s1_move || (s2_valid_ff && !s2_move);
      rsp_valid_in = (s2_move && s2_last_ff) || (rsp_valid_ff && !rsp_ready);
      acc_in       = acc_ff;
      if (s2_move) begin
         acc_in = s2_last_ff ? '0 : row_sum;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cb_low_ff    <= '0;
         cb_high_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         cb_low_ff    <= cb_low_in;
         cb_high_ff   <= cb_high_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_index_ff <= {req_index_high, req_index_low};
         s1_act_ff   <= {req_act_high, req_act_low};
         s1_last_ff  <= req_last;
      end
      if (s1_move) begin
         s2_prod_ff <= lane_prod;
         s2_last_ff <= s1_last_ff;
      end
      if (s2_move && s2_last_ff) begin
         rsp_dot_sum_ff <= row_sum;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot_sum = rsp_dot_sum_ff;

endmodule

@@ rtl/core/cbdp_checker.sv @@
// Port checker for the codebook int8 dot product block, bound to the top level.
// Depends on cbdp_pkg; watches the top level ports only.
`timescale 1ns / 1ps

module cbdp_checker
   import cbdp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_last,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [ACC_W-1:0] rsp_dot_sum
);

   // rows closed by a last request but not yet delivered
   logic [2:0] pending_ff, pending_in;
   logic       last_take, rsp_take;

   assign last_take = req_valid && req_ready && req_last;
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (last_take && !rsp_take) begin
         pending_in = pending_ff + 3'd1;
      end else if (!last_take && rsp_take) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dot_sum))
      else $error("result changed while stalled");

   // with no result waiting the pipeline always drains, so requests are taken
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with the result register empty");

   // a result needs a closed row behind it
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without a last request");

   // at most one closed row per pipeline register
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more closed rows in flight than pipeline registers");

endmodule

bind codebook_int8_dot_product cbdp_checker u_cbdp_checker (.*);
